/* rtl/gbn_pkg.sv */
// gbn_pkg: shared widths, codes, state and command types for the go-back-n link controller
// no dependencies; imported by the interfaces, gbn_ctrl, gbn_dp and the top level
package gbn_pkg;

  localparam int SEQ_BITS    = 3;
  localparam int HANDLE_BITS = 16;
  localparam int LEN_BITS    = 9;
  localparam int MAX_PAYLOAD = 256;
  localparam int MAX_SEQ     = (1 << SEQ_BITS) - 1;
  localparam int WIN_DEPTH   = 1 << SEQ_BITS;
  localparam int CNT_BITS    = SEQ_BITS + 1;

  typedef enum logic [2:0] {
    REQ_PKT   = 3'd0,
    REQ_LINK  = 3'd1,
    REQ_FRAME = 3'd2,
    REQ_DTO   = 3'd3,
    REQ_ATO   = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_NAK  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_SEND    = 3'd1,
    ACT_ACK     = 3'd2,
    ACT_NAK     = 3'd3,
    ACT_DELIVER = 3'd4,
    ACT_STOP    = 3'd5
  } act_t;

  typedef enum logic [1:0] {
    ATC_NONE  = 2'd0,
    ATC_START = 2'd1,
    ATC_STOP  = 2'd2
  } atc_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_ACK,
    ST_GOBACK,
    ST_RESEND
  } st_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic emit;
    act_t act;
    logic last;
    logic win_write;
    logic link_set;
    logic link_clr;
    logic nak_set;
    logic nak_clr;
    logic rx_adv;
    logic cnt_load_acks;
    logic ack_step;
    logic gb_start;
    logic resend_step;
  } gbn_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] req;
    logic       good;
    logic [1:0] kind;
    logic       in_seq;
    logic       nak_ok;
    logic       pkt_ok;
    logic       ack_zero;
    logic       cnt_one;
    logic       outst_zero;
    logic       outst_one;
    logic       out_free;
  } gbn_sts_t;

  // frames released by an ack number: ack in [oldest, next) cyclically
  function automatic logic [CNT_BITS-1:0] acked_count(input logic [SEQ_BITS-1:0] a,
                                                      input logic [SEQ_BITS-1:0] b,
                                                      input logic [SEQ_BITS-1:0] c);
    logic                inw;
    logic [SEQ_BITS-1:0] d;
    inw = ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
    d   = b - a;
    return inw ? (CNT_BITS'(d) + CNT_BITS'(1)) : '0;
  endfunction

endpackage

/* rtl/gbn_in_if.sv */
// gbn_in_if: event channel, valid/ready handshake plus the event fields
// depends on gbn_pkg for field widths
interface gbn_in_if;
  import gbn_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [2:0]             req_type;
  logic [HANDLE_BITS-1:0] pkt_handle;
  logic [LEN_BITS-1:0]    pkt_len;
  logic                   frame_good;
  logic [1:0]             frame_kind;
  logic [SEQ_BITS-1:0]    frame_seq;
  logic [SEQ_BITS-1:0]    peer_ack;

  modport source (
    output valid, req_type, pkt_handle, pkt_len, frame_good, frame_kind, frame_seq, peer_ack,
    input  ready
  );
  modport sink (
    input  valid, req_type, pkt_handle, pkt_len, frame_good, frame_kind, frame_seq, peer_ack,
    output ready
  );
endinterface

/* rtl/gbn_out_if.sv */
// gbn_out_if: action channel, valid/ready handshake plus the action fields
// depends on gbn_pkg for field widths
interface gbn_out_if;
  import gbn_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [2:0]             action;
  logic [SEQ_BITS-1:0]    out_seq;
  logic [SEQ_BITS-1:0]    out_ack;
  logic [HANDLE_BITS-1:0] out_handle;
  logic [LEN_BITS-1:0]    out_len;
  logic                   start_data_timer;
  logic [1:0]             ack_timer_cmd;
  logic                   net_enable;
  logic                   last;

  modport source (
    output valid, action, out_seq, out_ack, out_handle, out_len, start_data_timer,
           ack_timer_cmd, net_enable, last,
    input  ready
  );
  modport sink (
    input  valid, action, out_seq, out_ack, out_handle, out_len, start_data_timer,
           ack_timer_cmd, net_enable, last,
    output ready
  );
endinterface

/* rtl/gbn_ctrl.sv */
// gbn_ctrl: event sequencer, walks one event through head, ack release and go-back phases
// depends on gbn_pkg; drives gbn_dp through gbn_cmd_t and reads gbn_sts_t
module gbn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gbn_pkg::gbn_sts_t sts,
  output gbn_pkg::gbn_cmd_t cmd
);
  import gbn_pkg::*;

  st_t  state_r, state_nxt;
  logic nak_frame;

  assign nak_frame = (sts.req == REQ_FRAME) && sts.good && (sts.kind == KIND_NAK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.act   = ACT_NONE;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
          cmd.last  = 1'b1;
          case (sts.req)
            REQ_PKT: begin
              cmd.emit = 1'b1;
              if (sts.pkt_ok) begin
                cmd.act       = ACT_SEND;
                cmd.win_write = 1'b1;
              end
            end
            REQ_LINK: begin
              cmd.emit     = 1'b1;
              cmd.link_set = 1'b1;
            end
            REQ_FRAME: begin
              if (!sts.good) begin
                cmd.emit = 1'b1;
                if (sts.nak_ok) begin
                  cmd.act     = ACT_NAK;
                  cmd.nak_clr = 1'b1;
                end
              end else if (sts.kind == KIND_DATA) begin
                cmd.last          = sts.ack_zero;
                cmd.cnt_load_acks = 1'b1;
                if (sts.in_seq) begin
                  cmd.emit    = 1'b1;
                  cmd.act     = ACT_DELIVER;
                  cmd.nak_set = 1'b1;
                  cmd.rx_adv  = 1'b1;
                end else if (sts.nak_ok) begin
                  cmd.emit    = 1'b1;
                  cmd.act     = ACT_NAK;
                  cmd.nak_clr = 1'b1;
                end else begin
                  cmd.emit = sts.ack_zero;
                end
                if (!sts.ack_zero) begin
                  state_nxt = ST_ACK;
                end
              end else if (sts.kind == KIND_ACK) begin
                cmd.cnt_load_acks = 1'b1;
                cmd.emit          = sts.ack_zero;
                if (!sts.ack_zero) begin
                  state_nxt = ST_ACK;
                end
              end else if (sts.kind == KIND_NAK) begin
                cmd.last          = 1'b0;
                cmd.cnt_load_acks = 1'b1;
                state_nxt         = sts.ack_zero ? ST_GOBACK : ST_ACK;
              end else begin
                // unused frame kind is dropped
                cmd.emit = 1'b1;
              end
            end
            REQ_DTO: begin
              cmd.last  = 1'b0;
              state_nxt = ST_GOBACK;
            end
            REQ_ATO: begin
              cmd.emit = 1'b1;
              cmd.act  = ACT_ACK;
            end
            default: begin
              cmd.emit = 1'b1;
            end
          endcase
        end
      end
      ST_ACK: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.act      = ACT_STOP;
          cmd.ack_step = 1'b1;
          cmd.last     = sts.cnt_one && !(nak_frame && !sts.outst_one);
          if (sts.cnt_one) begin
            // a nak frame always drops the link flag; it ends in a go-back unless it released every outstanding frame
            cmd.link_clr = nak_frame;
            state_nxt    = (nak_frame && !sts.outst_one) ? ST_GOBACK : ST_IDLE;
          end
        end
      end
      ST_GOBACK: begin
        if (sts.out_free) begin
          cmd.gb_start = 1'b1;
          cmd.link_clr = 1'b1;
          if (sts.outst_zero) begin
            cmd.emit  = 1'b1;
            cmd.last  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_RESEND;
          end
        end
      end
      ST_RESEND: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.act         = ACT_SEND;
          cmd.resend_step = 1'b1;
          cmd.last        = sts.cnt_one;
          if (sts.cnt_one) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/gbn_dp.sv */
// gbn_dp: window store, sequence pointers, link flags, event capture and action register
// depends on gbn_pkg; commanded by gbn_ctrl
module gbn_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  gbn_pkg::gbn_cmd_t               cmd,
  output gbn_pkg::gbn_sts_t               sts,
  input  logic [2:0]                      req_type,
  input  logic [gbn_pkg::HANDLE_BITS-1:0] pkt_handle,
  input  logic [gbn_pkg::LEN_BITS-1:0]    pkt_len,
  input  logic                            frame_good,
  input  logic [1:0]                      frame_kind,
  input  logic [gbn_pkg::SEQ_BITS-1:0]    frame_seq,
  input  logic [gbn_pkg::SEQ_BITS-1:0]    peer_ack,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [2:0]                      action,
  output logic [gbn_pkg::SEQ_BITS-1:0]    out_seq,
  output logic [gbn_pkg::SEQ_BITS-1:0]    out_ack,
  output logic [gbn_pkg::HANDLE_BITS-1:0] out_handle,
  output logic [gbn_pkg::LEN_BITS-1:0]    out_len,
  output logic                            start_data_timer,
  output logic [1:0]                      ack_timer_cmd,
  output logic                            net_enable,
  output logic                            last
);
  import gbn_pkg::*;

  // link state
  logic [SEQ_BITS-1:0] next_send_r, next_send_nxt;
  logic [SEQ_BITS-1:0] oldest_r, oldest_nxt;
  logic [SEQ_BITS-1:0] rx_exp_r, rx_exp_nxt;
  logic [CNT_BITS-1:0] outst_r, outst_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                nak_ok_r, nak_ok_nxt;
  logic                link_r, link_nxt;
  logic                out_valid_r, out_valid_nxt;

  // send window, only slots written by a send are read back
  logic [HANDLE_BITS-1:0] win_handle_r [WIN_DEPTH];
  logic [LEN_BITS-1:0]    win_len_r    [WIN_DEPTH];

  // captured event
  logic [2:0]             req_r;
  logic [HANDLE_BITS-1:0] handle_r;
  logic [LEN_BITS-1:0]    len_r;
  logic                   good_r;
  logic [1:0]             kind_r;
  logic [SEQ_BITS-1:0]    seq_r;
  logic [SEQ_BITS-1:0]    ack_r;
  logic                   en_r;

  // action register
  logic [2:0]             act_r;
  logic [SEQ_BITS-1:0]    seq_out_r;
  logic [SEQ_BITS-1:0]    ack_out_r;
  logic [HANDLE_BITS-1:0] handle_out_r;
  logic [LEN_BITS-1:0]    len_out_r;
  logic                   sdt_r;
  logic [1:0]             atc_r;
  logic                   en_out_r;
  logic                   last_r;

  logic [LEN_BITS-1:0]    len_sat;
  logic [CNT_BITS-1:0]    acked_in;
  logic [CNT_BITS-1:0]    acked_cap;
  logic                   link_after;
  logic [CNT_BITS-1:0]    outst_after;
  logic                   en_after;
  logic                   pkt_ok;
  logic [SEQ_BITS-1:0]    e_seq;
  logic [HANDLE_BITS-1:0] e_handle;
  logic [LEN_BITS-1:0]    e_len;
  logic [1:0]             e_atc;

  assign len_sat   = (pkt_len > LEN_BITS'(MAX_PAYLOAD)) ? LEN_BITS'(MAX_PAYLOAD) : pkt_len;
  assign pkt_ok    = (outst_r < CNT_BITS'(MAX_SEQ)) && link_r;
  assign acked_in  = acked_count(oldest_r, peer_ack, next_send_r);
  assign acked_cap = acked_count(oldest_r, ack_r, next_send_r);

  // net enable as the state will stand once the whole event is done
  always_comb begin
    link_after  = link_r;
    outst_after = outst_r;
    case (req_type)
      REQ_PKT: begin
        if (pkt_ok) begin
          link_after = 1'b0;
        end
      end
      REQ_LINK: begin
        link_after = 1'b1;
      end
      REQ_FRAME: begin
        if (frame_good && (frame_kind == KIND_NAK)) begin
          link_after = 1'b0;
        end
        if (frame_good && ((frame_kind == KIND_DATA) || (frame_kind == KIND_ACK))) begin
          outst_after = outst_r - acked_in;
        end
      end
      REQ_DTO: begin
        link_after = 1'b0;
      end
      default: begin
        link_after = link_r;
      end
    endcase
    en_after = link_after && (outst_after < CNT_BITS'(MAX_SEQ));
  end

  always_comb begin
    sts.req        = req_r;
    sts.good       = good_r;
    sts.kind       = kind_r;
    sts.in_seq     = (seq_r == rx_exp_r);
    sts.nak_ok     = nak_ok_r;
    sts.pkt_ok     = pkt_ok;
    sts.ack_zero   = (acked_cap == '0);
    sts.cnt_one    = (cnt_r == CNT_BITS'(1));
    sts.outst_zero = (outst_r == '0);
    sts.outst_one  = (outst_r == CNT_BITS'(1));
    sts.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    next_send_nxt = next_send_r;
    oldest_nxt    = oldest_r;
    rx_exp_nxt    = rx_exp_r;
    outst_nxt     = outst_r;
    cnt_nxt       = cnt_r;
    nak_ok_nxt    = nak_ok_r;
    link_nxt      = link_r;
    if (cmd.win_write) begin
      next_send_nxt = next_send_r + SEQ_BITS'(1);
      outst_nxt     = outst_r + CNT_BITS'(1);
      link_nxt      = 1'b0;
    end
    if (cmd.link_set) begin
      link_nxt = 1'b1;
    end
    if (cmd.link_clr) begin
      link_nxt = 1'b0;
    end
    if (cmd.nak_set) begin
      nak_ok_nxt = 1'b1;
    end
    if (cmd.nak_clr) begin
      nak_ok_nxt = 1'b0;
    end
    if (cmd.rx_adv) begin
      rx_exp_nxt = rx_exp_r + SEQ_BITS'(1);
    end
    if (cmd.cnt_load_acks) begin
      cnt_nxt = acked_cap;
    end
    if (cmd.ack_step) begin
      oldest_nxt = oldest_r + SEQ_BITS'(1);
      outst_nxt  = outst_r - CNT_BITS'(1);
      cnt_nxt    = cnt_r - CNT_BITS'(1);
    end
    if (cmd.gb_start) begin
      next_send_nxt = oldest_r;
      cnt_nxt       = outst_r;
    end
    if (cmd.resend_step) begin
      next_send_nxt = next_send_r + SEQ_BITS'(1);
      cnt_nxt       = cnt_r - CNT_BITS'(1);
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_send_r <= '0;
      oldest_r    <= '0;
      rx_exp_r    <= '0;
      outst_r     <= '0;
      cnt_r       <= '0;
      nak_ok_r    <= 1'b1;
      link_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      next_send_r <= next_send_nxt;
      oldest_r    <= oldest_nxt;
      rx_exp_r    <= rx_exp_nxt;
      outst_r     <= outst_nxt;
      cnt_r       <= cnt_nxt;
      nak_ok_r    <= nak_ok_nxt;
      link_r      <= link_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r    <= req_type;
      handle_r <= pkt_handle;
      len_r    <= len_sat;
      good_r   <= frame_good;
      kind_r   <= frame_kind;
      seq_r    <= frame_seq;
      ack_r    <= peer_ack;
      en_r     <= en_after;
    end
    if (cmd.win_write) begin
      win_handle_r[next_send_r] <= handle_r;
      win_len_r[next_send_r]    <= len_r;
    end
  end

  // payload of the action being issued
  always_comb begin
    e_seq    = '0;
    e_handle = '0;
    e_len    = '0;
    e_atc    = ATC_NONE;
    case (cmd.act)
      ACT_SEND: begin
        e_seq    = next_send_r;
        e_handle = cmd.win_write ? handle_r : win_handle_r[next_send_r];
        e_len    = cmd.win_write ? len_r : win_len_r[next_send_r];
        e_atc    = ATC_STOP;
      end
      ACT_DELIVER: begin
        e_handle = handle_r;
        e_len    = len_r;
        e_atc    = ATC_START;
      end
      ACT_NAK, ACT_ACK: begin
        e_atc = ATC_STOP;
      end
      ACT_STOP: begin
        e_seq = oldest_r;
      end
      default: begin
        e_atc = ATC_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      act_r        <= cmd.act;
      seq_out_r    <= e_seq;
      ack_out_r    <= rx_exp_r + SEQ_BITS'(MAX_SEQ);
      handle_out_r <= e_handle;
      len_out_r    <= e_len;
      sdt_r        <= (cmd.act == ACT_SEND);
      atc_r        <= e_atc;
      en_out_r     <= en_r;
      last_r       <= cmd.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign action           = act_r;
  assign out_seq          = seq_out_r;
  assign out_ack          = ack_out_r;
  assign out_handle       = handle_out_r;
  assign out_len          = len_out_r;
  assign start_data_timer = sdt_r;
  assign ack_timer_cmd    = atc_r;
  assign net_enable       = en_out_r;
  assign last             = last_r;

endmodule

/* rtl/go_back_n_link_controller_unit.sv */
// go-back-n link controller: one event in, a run of 1 to 8 actions out, each issued once the
//   action register is free; the head state issues the first action unless the event has none,
//   then come ack releases, a go-back rewind and resends, and the action register may wait on
//   out_ch.ready; a new event is taken only once the run is done and the sequencer is idle
// reset: synchronous, active low; clears pointers, counts, link flag and valid; sets nak flag
module go_back_n_link_controller_unit (
  input  logic      clk,
  input  logic      rst_n,
  gbn_in_if.sink    in_ch,
  gbn_out_if.source out_ch
);
  import gbn_pkg::*;

  // command and status between the sequencer and the datapath
  gbn_cmd_t cmd;
  gbn_sts_t sts;

  // sequencer: takes an event only when idle, then walks
  // head action -> ack releases -> go-back rewind -> resends
  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: window slots, seq pointers, flags, captured event and the output register
  // which lets the sequencer keep working while the last action waits downstream
  gbn_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .req_type         (in_ch.req_type),
    .pkt_handle       (in_ch.pkt_handle),
    .pkt_len          (in_ch.pkt_len),
    .frame_good       (in_ch.frame_good),
    .frame_kind       (in_ch.frame_kind),
    .frame_seq        (in_ch.frame_seq),
    .peer_ack         (in_ch.peer_ack),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .action           (out_ch.action),
    .out_seq          (out_ch.out_seq),
    .out_ack          (out_ch.out_ack),
    .out_handle       (out_ch.out_handle),
    .out_len          (out_ch.out_len),
    .start_data_timer (out_ch.start_data_timer),
    .ack_timer_cmd    (out_ch.ack_timer_cmd),
    .net_enable       (out_ch.net_enable),
    .last             (out_ch.last)
  );

endmodule

/* bench/gbn_link_sb_pkg.sv */
// gbn_link_sb_pkg: event and action records plus the scoreboard for the go-back-n link controller
// depends on gbn_pkg for widths and codes; compiled after the rtl interfaces, before tb
package gbn_link_sb_pkg;
  import gbn_pkg::*;

  // codes the rtl package leaves unnamed
  localparam logic [2:0] REQ_RSVD_LO = 3'd5;
  localparam logic [2:0] REQ_RSVD_HI = 3'd7;
  localparam logic [1:0] KIND_RSVD   = 2'd3;
  localparam int         MAX_RUN     = 16;

  typedef struct {
    logic [2:0]             req;
    logic                   good;
    logic [1:0]             kind;
    logic [SEQ_BITS-1:0]    seq;
    logic [SEQ_BITS-1:0]    ack;
    logic [HANDLE_BITS-1:0] handle;
    logic [LEN_BITS-1:0]    len;
  } link_event_t;

  typedef struct {
    logic [2:0]             action;
    logic [SEQ_BITS-1:0]    seq;
    logic [SEQ_BITS-1:0]    ack;
    logic [HANDLE_BITS-1:0] handle;
    logic [LEN_BITS-1:0]    len;
    logic                   sdt;
    logic [1:0]             atc;
    logic                   net_en;
    logic                   last;
  } link_action_t;

  class link_scoreboard;
    // protocol state mirrored from the block
    logic [SEQ_BITS-1:0]    tx_next;
    logic [SEQ_BITS-1:0]    tx_base;
    logic [SEQ_BITS-1:0]    rx_next;
    int unsigned            in_flight;
    bit                     nak_ok;
    bit                     link_up;
    logic [HANDLE_BITS-1:0] win_handle [WIN_DEPTH];
    logic [LEN_BITS-1:0]    win_len [WIN_DEPTH];

    link_action_t           run_q[$];
    link_action_t           action_q[$];

    int unsigned errors;
    int unsigned n_events;
    int unsigned n_checked;
    int unsigned n_delivered;
    int unsigned n_resent;
    int unsigned n_stopped;
    int unsigned peak_flight;

    function new();
      tx_next = '0;
      tx_base = '0;
      rx_next = '0;
      in_flight = 0;
      nak_ok = 1'b1;
      link_up = 1'b0;
      foreach (win_handle[i]) begin
        win_handle[i] = '0;
        win_len[i] = '0;
      end
    endfunction

    function int unsigned waiting();
      return action_q.size();
    endfunction

    function logic [LEN_BITS-1:0] clip_len(logic [LEN_BITS-1:0] len);
      return (len > MAX_PAYLOAD) ? LEN_BITS'(MAX_PAYLOAD) : len;
    endfunction

    // ack number reflects rx_next at the moment the action is issued
    function void push_action(act_t act, logic [SEQ_BITS-1:0] seq,
                              logic [HANDLE_BITS-1:0] handle, logic [LEN_BITS-1:0] len,
                              logic sdt, atc_t atc);
      link_action_t a;
      if (run_q.size() >= MAX_RUN) return;
      a.action = act;
      a.seq = seq;
      a.ack = rx_next - SEQ_BITS'(1);
      a.handle = handle;
      a.len = len;
      a.sdt = sdt;
      a.atc = atc;
      a.net_en = 1'b0;
      a.last = 1'b0;
      run_q.push_back(a);
    endfunction

    // b lies in [a, c) on the sequence circle
    function bit in_span(logic [SEQ_BITS-1:0] a, logic [SEQ_BITS-1:0] b,
                         logic [SEQ_BITS-1:0] c);
      return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
    endfunction

    function void rewind();
      tx_next = tx_base;
      for (int i = 0; i < in_flight; i++) begin
        push_action(ACT_SEND, tx_next, win_handle[tx_next], win_len[tx_next], 1'b1, ATC_STOP);
        tx_next = tx_next + SEQ_BITS'(1);
        n_resent++;
      end
      link_up = 1'b0;
    endfunction

    function void note_event(link_event_t ev);
      logic en;
      run_q.delete();
      n_events++;
      case (ev.req)
        REQ_PKT: begin
          if (in_flight < MAX_SEQ && link_up) begin
            win_handle[tx_next] = ev.handle;
            win_len[tx_next] = clip_len(ev.len);
            in_flight++;
            push_action(ACT_SEND, tx_next, ev.handle, clip_len(ev.len), 1'b1, ATC_STOP);
            tx_next = tx_next + SEQ_BITS'(1);
            link_up = 1'b0;
          end
        end
        REQ_LINK: link_up = 1'b1;
        REQ_FRAME: begin
          if (!ev.good) begin
            if (nak_ok) begin
              push_action(ACT_NAK, '0, '0, '0, 1'b0, ATC_STOP);
              nak_ok = 1'b0;
            end
          end else if (ev.kind != KIND_RSVD) begin
            if (ev.kind == KIND_DATA) begin
              if (ev.seq == rx_next) begin
                push_action(ACT_DELIVER, '0, ev.handle, clip_len(ev.len), 1'b0, ATC_START);
                nak_ok = 1'b1;
                rx_next = rx_next + SEQ_BITS'(1);
                n_delivered++;
              end else if (nak_ok) begin
                push_action(ACT_NAK, '0, '0, '0, 1'b0, ATC_STOP);
                nak_ok = 1'b0;
              end
            end
            while (in_flight > 0 && in_span(tx_base, ev.ack, tx_next)) begin
              in_flight--;
              push_action(ACT_STOP, tx_base, '0, '0, 1'b0, ATC_NONE);
              tx_base = tx_base + SEQ_BITS'(1);
              n_stopped++;
            end
            if (ev.kind == KIND_NAK) rewind();
          end
        end
        REQ_DTO: rewind();
        REQ_ATO: push_action(ACT_ACK, '0, '0, '0, 1'b0, ATC_STOP);
        default: ;
      endcase
      if (run_q.size() == 0) push_action(ACT_NONE, '0, '0, '0, 1'b0, ATC_NONE);
      if (in_flight > peak_flight) peak_flight = in_flight;
      en = (in_flight < MAX_SEQ) && link_up;
      foreach (run_q[k]) begin
        run_q[k].net_en = en;
        run_q[k].last = (k == run_q.size() - 1);
        action_q.push_back(run_q[k]);
      end
    endfunction

    function bit field_ok(string name, logic [HANDLE_BITS-1:0] want,
                          logic [HANDLE_BITS-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_action(link_action_t got);
      link_action_t want;
      bit ok;
      if (action_q.size() == 0) begin
        $error("action %0d with nothing expected", got.action);
        errors++;
        return;
      end
      want = action_q.pop_front();
      n_checked++;
      ok = 1'b1;
      ok &= field_ok("action", HANDLE_BITS'(want.action), HANDLE_BITS'(got.action));
      ok &= field_ok("out_seq", HANDLE_BITS'(want.seq), HANDLE_BITS'(got.seq));
      ok &= field_ok("out_ack", HANDLE_BITS'(want.ack), HANDLE_BITS'(got.ack));
      ok &= field_ok("out_handle", want.handle, got.handle);
      ok &= field_ok("out_len", HANDLE_BITS'(want.len), HANDLE_BITS'(got.len));
      ok &= field_ok("start_data_timer", HANDLE_BITS'(want.sdt), HANDLE_BITS'(got.sdt));
      ok &= field_ok("ack_timer_cmd", HANDLE_BITS'(want.atc), HANDLE_BITS'(got.atc));
      ok &= field_ok("net_enable", HANDLE_BITS'(want.net_en), HANDLE_BITS'(got.net_en));
      ok &= field_ok("last", HANDLE_BITS'(want.last), HANDLE_BITS'(got.last));
      if (!ok) errors++;
    endfunction
  endclass

endpackage

/* bench/tb.sv */
// tb: self-checking bench for go_back_n_link_controller_unit, directed events then random traffic
// depends on gbn_pkg, gbn_in_if, gbn_out_if, the dut and gbn_link_sb_pkg
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gbn_pkg::*;
  import gbn_link_sb_pkg::*;

  localparam int RANDOM_ITEMS = 200;
  localparam int CALM_ITEMS   = 40;      // tail of the run with no idling on either side
  localparam int CYCLE_LIMIT  = 300000;  // worst case is far below this
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst_n;

  gbn_in_if  in_ch ();
  gbn_out_if out_ch ();

  go_back_n_link_controller_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  link_scoreboard sb;

  bit          calm;
  int unsigned stall_pct;
  int unsigned stall_left;
  int unsigned gap_pct;
  int unsigned cycle_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure: ready drops in random bursts
  always @(negedge clk) begin
    if (calm) begin
      stall_left = 0;
      out_ch.ready = 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ch.ready = 1'b0;
    end else if ($urandom_range(99) < stall_pct) begin
      // this cycle counts as the first of the burst
      stall_left = $urandom_range(0, 14);
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // result monitor and watchdog, both on the rising edge
  always @(posedge clk) begin
    link_action_t got;
    cycle_count++;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.action = out_ch.action;
      got.seq = out_ch.out_seq;
      got.ack = out_ch.out_ack;
      got.handle = out_ch.out_handle;
      got.len = out_ch.out_len;
      got.sdt = out_ch.start_data_timer;
      got.atc = out_ch.ack_timer_cmd;
      got.net_en = out_ch.net_enable;
      got.last = out_ch.last;
      sb.check_action(got);
    end
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic link_event_t make_event(logic [2:0] req, logic good, logic [1:0] kind,
                                             logic [SEQ_BITS-1:0] seq,
                                             logic [SEQ_BITS-1:0] ack,
                                             logic [HANDLE_BITS-1:0] handle,
                                             logic [LEN_BITS-1:0] len);
    link_event_t ev;
    ev.req = req;
    ev.good = good;
    ev.kind = kind;
    ev.seq = seq;
    ev.ack = ack;
    ev.handle = handle;
    ev.len = len;
    return ev;
  endfunction

  // present one item at the falling edge, hold it until the block takes it
  task automatic send_event(input link_event_t ev);
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.req_type = ev.req;
    in_ch.frame_good = ev.good;
    in_ch.frame_kind = ev.kind;
    in_ch.frame_seq = ev.seq;
    in_ch.peer_ack = ev.ack;
    in_ch.pkt_handle = ev.handle;
    in_ch.pkt_len = ev.len;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_event(ev);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    @(negedge clk);
    in_ch.valid = 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold the sender off until every predicted action has come out
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
  endtask

  // mostly well-formed protocol traffic steered by the predicted state, plus some noise
  function automatic link_event_t pick_event();
    link_event_t ev;
    int unsigned r;
    ev.req = REQ_FRAME;
    ev.good = 1'b1;
    ev.kind = KIND_DATA;
    ev.seq = SEQ_BITS'($urandom);
    ev.ack = SEQ_BITS'($urandom);
    ev.handle = HANDLE_BITS'($urandom);
    ev.len = LEN_BITS'($urandom_range(0, MAX_PAYLOAD));
    // oversize lengths exercise the top length bit and the clipping
    if ($urandom_range(99) < 15)
      ev.len = LEN_BITS'($urandom_range(MAX_PAYLOAD + 1, (1 << LEN_BITS) - 1));
    // acks mostly land inside the outstanding window
    if (sb.in_flight != 0 && $urandom_range(99) < 80)
      ev.ack = sb.tx_base + SEQ_BITS'($urandom_range(0, sb.in_flight - 1));
    r = $urandom_range(99);
    if (r < 25) begin
      ev.req = REQ_LINK;
    end else if (r < 50) begin
      ev.req = REQ_PKT;
    end else if (r < 65) begin
      // data frame, usually the one the receiver is waiting for
      if ($urandom_range(99) < 70) ev.seq = sb.rx_next;
    end else if (r < 75) begin
      ev.kind = KIND_ACK;
    end else if (r < 80) begin
      ev.kind = KIND_NAK;
    end else if (r < 85) begin
      ev.req = REQ_DTO;
    end else if (r < 89) begin
      ev.req = REQ_ATO;
    end else if (r < 95) begin
      // corrupted frame of any kind
      ev.good = 1'b0;
      ev.kind = 2'($urandom);
    end else if ($urandom_range(1) == 1) begin
      ev.req = REQ_RSVD_LO + 3'($urandom_range(0, 2));
    end else begin
      ev.kind = KIND_RSVD;
    end
    return ev;
  endfunction

  initial begin
    link_event_t ev;
    int unsigned n_items;
    int unsigned n_useful;
    sb = new();
    calm = 1'b0;
    stall_pct = 20;
    gap_pct = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_PKT;
    in_ch.frame_good = 1'b0;
    in_ch.frame_kind = KIND_DATA;
    in_ch.frame_seq = '0;
    in_ch.peer_ack = '0;
    in_ch.pkt_handle = '0;
    in_ch.pkt_len = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part
    // ack timeout straight out of reset, ack number wraps to the top
    send_event(make_event(REQ_ATO, 1'b0, KIND_DATA, '0, '0, '0, '0));
    // packet while the link is not ready gets ignored
    send_event(make_event(REQ_PKT, 1'b0, KIND_DATA, '0, '0, 16'h1234, 9'd10));
    send_event(make_event(REQ_LINK, 1'b0, KIND_DATA, '0, '0, '0, '0));
    // all-ones handle, length above the payload limit is clipped
    send_event(make_event(REQ_PKT, 1'b0, KIND_DATA, '0, '0, 16'hFFFF, 9'h1FF));
    send_event(make_event(REQ_LINK, 1'b0, KIND_DATA, '0, '0, '0, '0));
    send_event(make_event(REQ_PKT, 1'b0, KIND_DATA, '0, '0, 16'h0000, 9'd0));
    send_event(make_event(REQ_LINK, 1'b0, KIND_DATA, '0, '0, '0, '0));
    send_event(make_event(REQ_PKT, 1'b0, KIND_DATA, '0, '0, 16'hA5A5, 9'd256));
    // bad frame naks once, a second one stays quiet
    send_event(make_event(REQ_FRAME, 1'b0, KIND_DATA, 3'd0, 3'd0, '0, '0));
    send_event(make_event(REQ_FRAME, 1'b0, KIND_NAK, 3'd3, 3'd1, '0, '0));
    // in-order data frame delivers, ack outside the window releases nothing
    send_event(make_event(REQ_FRAME, 1'b1, KIND_DATA, 3'd0, 3'd7, 16'h5A5A, 9'd300));
    // out-of-order data frame naks again now that delivery re-armed it
    send_event(make_event(REQ_FRAME, 1'b1, KIND_DATA, 3'd5, 3'd7, 16'h0F0F, 9'd5));
    send_event(make_event(REQ_FRAME, 1'b1, KIND_ACK, 3'd0, 3'd0, '0, '0));
    // reserved frame kind and reserved requests are ignored
    send_event(make_event(REQ_FRAME, 1'b1, KIND_RSVD, 3'd7, 3'd7, 16'hFFFF, 9'h1FF));
    send_event(make_event(REQ_RSVD_LO, 1'b1, KIND_DATA, '0, '0, '0, '0));
    send_event(make_event(REQ_RSVD_HI, 1'b1, KIND_NAK, 3'd7, 3'd7, 16'hFFFF, 9'h1FF));
    // data timeout goes back over the two outstanding frames
    send_event(make_event(REQ_DTO, 1'b0, KIND_DATA, '0, '0, '0, '0));
    // nak frame releases one and resends the rest
    send_event(make_event(REQ_FRAME, 1'b1, KIND_NAK, 3'd0, 3'd1, '0, '0));
    // piggybacked ack on a delivery empties the window
    send_event(make_event(REQ_FRAME, 1'b1, KIND_DATA, 3'd1, 3'd2, 16'h8001, 9'd128));
    // timeout with nothing outstanding yields a run of a single no-op action
    send_event(make_event(REQ_DTO, 1'b0, KIND_DATA, '0, '0, '0, '0));
    drain_results();

    // random part; idling levels change every 25 items
    n_items = 0;
    n_useful = 0;
    while (n_useful < RANDOM_ITEMS) begin
      calm = (n_useful >= RANDOM_ITEMS - CALM_ITEMS);
      if (n_items % 25 == 0) begin
        case ($urandom_range(2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 40;
        endcase
        case ($urandom_range(2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 40;
        endcase
      end
      // sender waits out the whole backlog once mid-run
      if (n_items == 100) drain_results();
      if (!calm && $urandom_range(99) < gap_pct) idle_sender($urandom_range(1, 15));
      ev = pick_event();
      send_event(ev);
      // ignored noise does not count toward the item budget
      if (!(ev.req > REQ_ATO || (ev.req == REQ_FRAME && ev.good && ev.kind == KIND_RSVD)))
        n_useful++;
      n_items++;
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d events, %0d actions checked, window peaked at %0d frames",
             sb.n_events, sb.n_checked, sb.peak_flight);
    $display("run: %0d deliveries, %0d go-back resends, %0d timer stops",
             sb.n_delivered, sb.n_resent, sb.n_stopped);
    if (sb.errors == 0 && sb.waiting() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
